// File: hdl/ptq_pkg.sv
package ptq_pkg;

    localparam logic [2:0] CMD_ADD_NORMAL = 3'd0;
    localparam logic [2:0] CMD_ADD_TOP    = 3'd1;
    localparam logic [2:0] CMD_ADD_TIMED  = 3'd2;
    localparam logic [2:0] CMD_POP        = 3'd3;
    localparam logic [2:0] CMD_CANCEL     = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int TIME_W    = 48;
    localparam int PAYLOAD_W = 24;
    localparam int PRIO_W    = 8;

    localparam logic [0:0] REG_NORMAL_LIMIT = 1'd0;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] task_token;
        logic [7:0]  priority_req;
        logic [7:0]  owner_id;
        logic [31:0] delay_us;
        logic [47:0] now_us;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_token;
        logic [7:0]  out_owner;
        logic [7:0]  out_priority;
        logic        out_was_timed;
        logic [6:0]  removed_count;
        logic [6:0]  normal_count;
        logic [5:0]  timed_count;
    } t_out_item;

    typedef enum logic [1:0] {
        SOP_NONE   = 2'd0,
        SOP_INSERT = 2'd1,
        SOP_POP    = 2'd2,
        SOP_CANCEL = 2'd3
    } t_sop;

    typedef struct packed {
        t_sop       op;
        logic       tie_first;
        logic [7:0] owner;
    } t_store_req;

endpackage

// File: hdl/ptq_store.sv
module ptq_store #(
    parameter int DEPTH = 64,
    parameter int KEY_W = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  ptq_pkg::t_store_req                     i_req,
    input  logic [KEY_W-1:0]                        i_key,
    input  logic [ptq_pkg::PAYLOAD_W-1:0]           i_payload,
    output logic                                    o_busy,
    output logic [$clog2(DEPTH+1)-1:0]              o_count,
    output logic [$clog2(DEPTH+1)-1:0]              o_removed,
    output logic [ptq_pkg::PAYLOAD_W+KEY_W-1:0]     o_front
);
    import ptq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);
    localparam int EW = PAYLOAD_W + KEY_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INS  = 4'b0010,
        S_INS0 = 4'b0100,
        S_CMP  = 4'b1000
    } t_state;

    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] r_rd_data;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_removed, n_removed;
    logic [EW-1:0] r_new, n_new;
    logic          r_tie, n_tie;
    logic          r_pop, n_pop;
    logic [7:0]    r_owner, n_owner;
    logic [EW-1:0] r_front;

    logic          we;
    logic [CW-1:0] waddr_c, raddr_c;
    logic [EW-1:0] wdata;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr_c[AW-1:0]] <= wdata;
        end
        r_rd_data <= mem[raddr_c[AW-1:0]];
    end

    always_comb begin
        logic          shift;
        logic          drop;
        logic [CW-1:0] k_next;
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_k       = r_k;
        n_removed = r_removed;
        n_new     = r_new;
        n_tie     = r_tie;
        n_pop     = r_pop;
        n_owner   = r_owner;
        we        = 1'b0;
        waddr_c   = '0;
        wdata     = r_new;
        raddr_c   = '0;
        shift     = 1'b0;
        drop      = 1'b0;
        k_next    = r_k;
        unique case (r_state)
            S_IDLE: begin
                n_new   = {i_payload, i_key};
                n_tie   = i_req.tie_first;
                n_owner = i_req.owner;
                n_pop   = (i_req.op == SOP_POP);
                case (i_req.op)
                    SOP_INSERT: begin
                        if (r_count == '0) begin
                            we      = 1'b1;
                            wdata   = {i_payload, i_key};
                            n_count = CW'(1);
                        end else begin
                            raddr_c = r_count - 1'b1;
                            n_idx   = r_count - 1'b1;
                            n_state = S_INS;
                        end
                    end
                    SOP_POP, SOP_CANCEL: begin
                        n_removed = '0;
                        if (r_count != '0) begin
                            n_idx   = '0;
                            n_k     = '0;
                            n_state = S_CMP;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_INS: begin
                // Walk backward from the tail, moving every entry that the new one outranks.
                shift = r_tie ? (r_new[KEY_W-1:0] >= r_rd_data[KEY_W-1:0])
                              : (r_new[KEY_W-1:0] >  r_rd_data[KEY_W-1:0]);
                we      = 1'b1;
                waddr_c = r_idx + 1'b1;
                if (shift) begin
                    wdata = r_rd_data;
                    if (r_idx == '0) begin
                        n_state = S_INS0;
                    end else begin
                        raddr_c = r_idx - 1'b1;
                        n_idx   = r_idx - 1'b1;
                    end
                end else begin
                    wdata   = r_new;
                    n_count = r_count + 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_INS0: begin
                we      = 1'b1;
                waddr_c = '0;
                wdata   = r_new;
                n_count = r_count + 1'b1;
                n_state = S_IDLE;
            end
            S_CMP: begin
                // Forward compaction: kept entries slide down to the write index.
                drop = r_pop ? (r_idx == '0)
                             : (r_rd_data[KEY_W+7:KEY_W] == r_owner);
                if (!drop) begin
                    we      = 1'b1;
                    waddr_c = r_k;
                    wdata   = r_rd_data;
                    k_next  = r_k + 1'b1;
                end
                n_k = k_next;
                if (r_idx == r_count - 1'b1) begin
                    n_count   = k_next;
                    n_removed = r_idx + 1'b1 - k_next;
                    n_state   = S_IDLE;
                end else begin
                    raddr_c = r_idx + 1'b1;
                    n_idx   = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (r_state == S_CMP) begin
            raddr_c = r_idx + 1'b1;
        end else if (r_state == S_IDLE && (i_req.op == SOP_POP || i_req.op == SOP_CANCEL)) begin
            raddr_c = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_removed <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_removed <= n_removed;
        end
        r_idx   <= n_idx;
        r_k     <= n_k;
        r_new   <= n_new;
        r_tie   <= n_tie;
        r_pop   <= n_pop;
        r_owner <= n_owner;
        if (we && waddr_c == '0) begin
            r_front <= wdata;
        end
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_count   = r_count;
    assign o_removed = r_removed;
    assign o_front   = r_front;

endmodule

// File: hdl/priority_and_timed_task_queue.sv
// Task queue with a priority store for normal tasks and a deadline store for
// timed tasks, each held in its own single-port-write, registered-read memory.
// Input channel: i_in_valid / o_in_stall carry one command word (add normal,
// add top, add timed, pop, cancel owner). Output channel: o_out_valid /
// i_out_stall return exactly one result word per command.
// A command that touches no memory answers without a store walk. An ordered
// insert walks back from the tail one entry per cycle, and pop and cancel
// compact the store one entry per cycle; cancel walks both stores at once.
// With the default depths the longest walk is the one over the normal store.
// One command is in flight at a time; the next one is taken once its result
// sits in the output register, so a result may wait while the next command
// is already being processed if the receiver stalls only briefly.
// While i_out_stall is high a valid result holds and a finished command waits.
// Reset empties both stores and clears the normal-task limit register.
// The limit register sits at byte address 0 of the APB-style port.
module priority_and_timed_task_queue #(
    parameter int NORMAL_DEPTH = 64,
    parameter int TIMED_DEPTH  = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ptq_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ptq_pkg::t_out_item o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ptq_pkg::*;

    localparam int NCW = $clog2(NORMAL_DEPTH+1);
    localparam int TCW = $clog2(TIMED_DEPTH+1);

    typedef enum logic [1:0] {
        T_IDLE = 2'b01,
        T_WORK = 2'b10
    } t_tstate;

    t_tstate     r_state;
    logic [6:0]  r_limit;
    logic [1:0]  r_status;
    logic [15:0] r_tok;
    logic [7:0]  r_own;
    logic [7:0]  r_pri;
    logic        r_timed;
    logic        r_cancel;
    logic        r_ovalid;
    t_out_item   r_odata;

    t_store_req           n_req, t_req;
    logic [TIME_W-1:0]    deadline;
    logic [TIME_W:0]      dl_sum;
    logic                 n_busy, t_busy;
    logic [NCW-1:0]       n_count, n_removed;
    logic [TCW-1:0]       t_count, t_removed;
    logic [PAYLOAD_W+PRIO_W-1:0] n_front;
    logic [PAYLOAD_W+TIME_W-1:0] t_front;
    logic                 accept, done, normal_full, timed_due;
    logic [31:0]          cap;
    logic [1:0]           a_status;
    logic                 a_pop_timed, a_pop_normal;

    ptq_store #(.DEPTH(NORMAL_DEPTH), .KEY_W(PRIO_W)) u_normal (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (n_req),
        .i_key     (i_in_data.priority_req),
        .i_payload ({i_in_data.task_token, i_in_data.owner_id}),
        .o_busy    (n_busy),
        .o_count   (n_count),
        .o_removed (n_removed),
        .o_front   (n_front)
    );

    // Deadlines are stored inverted so both stores keep the larger key first.
    ptq_store #(.DEPTH(TIMED_DEPTH), .KEY_W(TIME_W)) u_timed (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (t_req),
        .i_key     (~deadline),
        .i_payload ({i_in_data.task_token, i_in_data.owner_id}),
        .o_busy    (t_busy),
        .o_count   (t_count),
        .o_removed (t_removed),
        .o_front   (t_front)
    );

    assign o_in_stall = (r_state != T_IDLE);
    assign accept     = i_in_valid && (r_state == T_IDLE);

    always_comb begin
        dl_sum   = {1'b0, i_in_data.now_us} + {17'd0, i_in_data.delay_us};
        deadline = dl_sum[TIME_W] ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];
        cap      = (r_limit == '0 || 32'(r_limit) > NORMAL_DEPTH)
                   ? 32'(NORMAL_DEPTH) : 32'(r_limit);
        normal_full = (32'(n_count) >= cap);
        timed_due   = (t_count != '0) && (~t_front[TIME_W-1:0] <= i_in_data.now_us);

        n_req        = '{op: SOP_NONE, tie_first: 1'b0, owner: i_in_data.owner_id};
        t_req        = '{op: SOP_NONE, tie_first: 1'b0, owner: i_in_data.owner_id};
        a_status     = ST_OK;
        a_pop_timed  = 1'b0;
        a_pop_normal = 1'b0;
        case (i_in_data.cmd)
            CMD_ADD_NORMAL, CMD_ADD_TOP: begin
                if (normal_full) begin
                    a_status = ST_FULL;
                end else begin
                    n_req.op        = SOP_INSERT;
                    n_req.tie_first = (i_in_data.cmd == CMD_ADD_TOP);
                end
            end
            CMD_ADD_TIMED: begin
                if (32'(t_count) >= TIMED_DEPTH) begin
                    a_status = ST_FULL;
                end else begin
                    t_req.op = SOP_INSERT;
                end
            end
            CMD_POP: begin
                if (timed_due) begin
                    a_pop_timed = 1'b1;
                    t_req.op    = SOP_POP;
                end else if (n_count != '0) begin
                    a_pop_normal = 1'b1;
                    n_req.op     = SOP_POP;
                end else begin
                    a_status = ST_EMPTY;
                end
            end
            CMD_CANCEL: begin
                n_req.op = SOP_CANCEL;
                t_req.op = SOP_CANCEL;
            end
            default: begin
            end
        endcase
        if (!accept) begin
            n_req.op = SOP_NONE;
            t_req.op = SOP_NONE;
        end
    end

    assign done = (r_state == T_WORK) && !n_busy && !t_busy && (!r_ovalid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= T_IDLE;
            r_limit  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr[2] == REG_NORMAL_LIMIT) begin
                r_limit <= pwdata[6:0];
            end
            unique case (r_state)
                T_IDLE: begin
                    if (accept) begin
                        r_state <= T_WORK;
                    end
                end
                T_WORK: begin
                    if (done) begin
                        r_state <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
            if (done) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
        if (accept) begin
            r_status <= a_status;
            r_cancel <= (i_in_data.cmd == CMD_CANCEL);
            r_timed  <= a_pop_timed;
            if (a_pop_timed) begin
                r_tok <= t_front[TIME_W+23:TIME_W+8];
                r_own <= t_front[TIME_W+7:TIME_W];
                r_pri <= '0;
            end else if (a_pop_normal) begin
                r_tok <= n_front[PRIO_W+23:PRIO_W+8];
                r_own <= n_front[PRIO_W+7:PRIO_W];
                r_pri <= n_front[PRIO_W-1:0];
            end else begin
                r_tok <= '0;
                r_own <= '0;
                r_pri <= '0;
            end
        end
        if (done) begin
            r_odata.status        <= r_status;
            r_odata.out_token     <= r_tok;
            r_odata.out_owner     <= r_own;
            r_odata.out_priority  <= r_pri;
            r_odata.out_was_timed <= r_timed;
            r_odata.removed_count <= r_cancel ? (7'(n_removed) + 7'(t_removed)) : 7'd0;
            r_odata.normal_count  <= 7'(n_count);
            r_odata.timed_count   <= 6'(t_count);
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;
    assign prdata      = (paddr[2] == REG_NORMAL_LIMIT) ? {25'd0, r_limit} : 32'd0;
    assign pready      = 1'b1;

endmodule
